// ----- hdl/mtn_pkg.sv -----
package mtn_pkg;

  localparam int CoordW  = 18;
  localparam int ZoomW   = 5;
  localparam int ActionW = 4;

  localparam logic [ZoomW-1:0] MaxZoom   = 5'd18;
  localparam logic [ZoomW-1:0] MinZoom   = 5'd2;
  localparam logic [ZoomW-1:0] ResetZoom = 5'd16;

  typedef enum logic [ActionW-1:0] {
    ActN       = 4'd0,
    ActS       = 4'd1,
    ActW       = 4'd2,
    ActE       = 4'd3,
    ActZoomNw  = 4'd4,
    ActZoomNe  = 4'd5,
    ActZoomSw  = 4'd6,
    ActZoomSe  = 4'd7,
    ActZoomIn  = 4'd8,
    ActZoomOut = 4'd9,
    ActCentre  = 4'd10,
    ActSetZoom = 4'd11
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [CoordW-1:0] auto_tile_x;
    logic [CoordW-1:0] auto_tile_y;
    logic [ZoomW-1:0]  new_zoom;
  } item_t;

  typedef struct packed {
    logic              zoom_done;
    logic              refresh_pending;
    logic [CoordW-1:0] view_y;
    logic [CoordW-1:0] view_x;
    logic              manual_mode;
    logic [ZoomW-1:0]  zoom_level;
  } result_t;

  // Handshake between the pipeline control and the result register.
  typedef struct packed {
    logic load;
    logic take;
  } out_ctrl_t;

  // Tile coordinates wrap modulo 2^zoom; at zoom 18 or above all bits stay.
  function automatic logic [CoordW-1:0] wrap_mask(input logic [ZoomW-1:0] zoom);
    logic [CoordW-1:0] m;
    for (int i = 0; i < CoordW; i++) begin
      m[i] = (ZoomW'(i) < zoom);
    end
    return m;
  endfunction

endpackage

// ----- hdl/map_tile_navigator.sv -----
// Map tile navigator: zoom level, manual flag, manual tile x/y, refresh flag.
// Path: an accepted input beat is registered in the input register, then
// passes through the next-state logic into the result register.
// Throughput: 1 beat per cycle while m_axis_tready does not stall the output.
// Reset: rst_ni asynchronous, active low; zoom 16, manual off, tile 0/0,
// refresh clear, both pipeline registers empty.
module map_tile_navigator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] action, [21:4] auto_tile_x, [39:22] auto_tile_y, [44:40] new_zoom,
  // [47:45] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] zoom_level, [5] manual_mode, [23:6] view_x, [41:24] view_y,
  // [42] refresh_pending, [43] zoom_done, [47:44] zero
  output logic [47:0] m_axis_tdata
);
  import mtn_pkg::*;

  item_t     in_item;
  item_t     stage_item;
  logic      stage_valid;
  logic      adv;
  out_ctrl_t out_ctrl;
  result_t   next_result;
  result_t   out_result;
  logic      out_valid;

  // Unpack the input beat.
  assign in_item.action      = action_e'(s_axis_tdata[3:0]);
  assign in_item.auto_tile_x = s_axis_tdata[21:4];
  assign in_item.auto_tile_y = s_axis_tdata[39:22];
  assign in_item.new_zoom    = s_axis_tdata[44:40];

  // Advance the staged item into the result register when that register is
  // free or being drained this cycle; the state update rides on the same edge.
  assign adv           = stage_valid && (!out_valid || m_axis_tready);
  assign out_ctrl.load = adv;
  assign out_ctrl.take = m_axis_tready;

  mtn_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  mtn_nav_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (stage_item),
    .result_o (next_result)
  );

  mtn_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (out_ctrl),
    .result_i (next_result),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

  // Pack the result beat.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000,
                          out_result.zoom_done,
                          out_result.refresh_pending,
                          out_result.view_y,
                          out_result.view_x,
                          out_result.manual_mode,
                          out_result.zoom_level};

  // A staged item that cannot advance stays staged.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !adv |=> stage_valid)
    else $error("staged item dropped while stalled");

  // Every advance leaves a result waiting in the output register.
  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid)
    else $error("advanced item produced no result");

  // Refresh is sticky: once reported, every later result reports it too.
  a_refresh_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_result.refresh_pending |=> out_result.refresh_pending)
    else $error("refresh flag cleared without reset");

endmodule

// ----- hdl/mtn_in_reg.sv -----
module mtn_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  mtn_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          valid_o,
  output mtn_pkg::item_t item_o
);
  import mtn_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign ready_o = !valid_q || adv_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hdl/mtn_nav_core.sv -----
module mtn_nav_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  mtn_pkg::item_t   item_i,
  output mtn_pkg::result_t result_o
);
  import mtn_pkg::*;

  logic [ZoomW-1:0]  zoom_q, zoom_d;
  logic              manual_q, manual_d;
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic              refresh_q, refresh_d;
  logic              done;
  logic              wrap_en;
  logic [CoordW-1:0] seed_x, seed_y;
  logic              zin_ok, zout_ok;
  logic              step_x, step_y;

  assign seed_x  = manual_q ? x_q : item_i.auto_tile_x;
  assign seed_y  = manual_q ? y_q : item_i.auto_tile_y;
  assign zin_ok  = (zoom_q < MaxZoom);
  assign zout_ok = (zoom_q > MinZoom);
  assign step_x  = (item_i.action == ActZoomNe) || (item_i.action == ActZoomSe);
  assign step_y  = (item_i.action == ActZoomSw) || (item_i.action == ActZoomSe);

  always_comb begin
    zoom_d    = zoom_q;
    manual_d  = manual_q;
    x_d       = x_q;
    y_d       = y_q;
    refresh_d = refresh_q;
    done      = 1'b0;
    wrap_en   = 1'b0;
    case (item_i.action)
      ActN, ActS, ActW, ActE: begin
        manual_d  = 1'b1;
        refresh_d = 1'b1;
        wrap_en   = 1'b1;
        x_d       = seed_x;
        y_d       = seed_y;
        if (item_i.action == ActN) begin
          y_d = seed_y - CoordW'(1);
        end else if (item_i.action == ActS) begin
          y_d = seed_y + CoordW'(1);
        end else if (item_i.action == ActW) begin
          x_d = seed_x - CoordW'(1);
        end else begin
          x_d = seed_x + CoordW'(1);
        end
      end
      ActZoomNw, ActZoomNe, ActZoomSw, ActZoomSe: begin
        manual_d = 1'b1;
        wrap_en  = 1'b1;
        x_d      = seed_x;
        y_d      = seed_y;
        if (zin_ok) begin
          zoom_d    = zoom_q + ZoomW'(1);
          done      = 1'b1;
          refresh_d = 1'b1;
          // low bit is free after the doubling, so the quadrant step is an OR
          x_d       = {seed_x[CoordW-2:0], step_x};
          y_d       = {seed_y[CoordW-2:0], step_y};
        end
      end
      ActZoomIn: begin
        if (zin_ok) begin
          zoom_d = zoom_q + ZoomW'(1);
          done   = 1'b1;
          if (manual_q) begin
            x_d       = {x_q[CoordW-2:0], 1'b0};
            y_d       = {y_q[CoordW-2:0], 1'b0};
            refresh_d = 1'b1;
          end
        end
      end
      ActZoomOut: begin
        if (zout_ok) begin
          zoom_d = zoom_q - ZoomW'(1);
          done   = 1'b1;
          if (manual_q) begin
            x_d       = {1'b0, x_q[CoordW-1:1]};
            y_d       = {1'b0, y_q[CoordW-1:1]};
            refresh_d = 1'b1;
          end
        end
      end
      ActCentre: begin
        manual_d = 1'b0;
      end
      ActSetZoom: begin
        zoom_d = item_i.new_zoom;
      end
      default: begin
      end
    endcase
    if (wrap_en) begin
      x_d = x_d & wrap_mask(zoom_d);
      y_d = y_d & wrap_mask(zoom_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q    <= ResetZoom;
      manual_q  <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      refresh_q <= 1'b0;
    end else if (adv_i) begin
      zoom_q    <= zoom_d;
      manual_q  <= manual_d;
      x_q       <= x_d;
      y_q       <= y_d;
      refresh_q <= refresh_d;
    end
  end

  assign result_o.zoom_level      = zoom_d;
  assign result_o.manual_mode     = manual_d;
  assign result_o.view_x          = x_d;
  assign result_o.view_y          = y_d;
  assign result_o.refresh_pending = refresh_d;
  assign result_o.zoom_done       = done;

endmodule

// ----- hdl/mtn_out_reg.sv -----
module mtn_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtn_pkg::out_ctrl_t ctrl_i,
  input  mtn_pkg::result_t   result_i,
  output logic               valid_o,
  output mtn_pkg::result_t   result_o
);
  import mtn_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end else if (ctrl_i.take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
